@@ rtl/core/hesd_pkg.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder package
// Shared constants, reference tables and types of the decoder.
// ----------------------------------------------------------------------------
package hesd_pkg;

   localparam int MaxDigits   = 6;
   localparam int NumNamed    = 9;
   localparam int NamedMaxLen = 8;
   localparam int NamedPosW   = $clog2(NamedMaxLen);
   localparam int PendDepth   = (MaxDigits + 4 > NamedMaxLen) ? MaxDigits + 4 : NamedMaxLen;
   localparam int CntW        = $clog2(PendDepth + 1);
   localparam int ValW        = 4 * MaxDigits;
   localparam int DigW        = $clog2(MaxDigits + 1);
   localparam int CpW         = 21;
   localparam int QueueDepth  = 4;
   localparam int QPtrW       = $clog2(QueueDepth);
   localparam int QCntW       = $clog2(QueueDepth + 1);

   localparam logic [31:0] CodeMax = 32'h0010_FFFF;

   localparam logic [1:0] LevelNamed   = 2'd0;
   localparam logic [1:0] LevelNumeric = 2'd1;
   localparam logic [1:0] LevelExtra   = 2'd2;

   localparam logic [7:0] CharAmp  = 8'h26;
   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharX    = 8'h78;
   localparam logic [7:0] CharSemi = 8'h3B;
   localparam logic [7:0] CharPad  = 8'h00;

   localparam logic [0:NumNamed-1][0:NamedMaxLen-1][7:0] NamedText = '{
      '{"&", "a", "m", "p", ";", CharPad, CharPad, CharPad},
      '{"&", "l", "t", ";", CharPad, CharPad, CharPad, CharPad},
      '{"&", "g", "t", ";", CharPad, CharPad, CharPad, CharPad},
      '{"&", "q", "u", "o", "t", ";", CharPad, CharPad},
      '{"&", "a", "p", "o", "s", ";", CharPad, CharPad},
      '{"&", "p", "l", "u", "s", ";", CharPad, CharPad},
      '{"&", "e", "q", "u", "a", "l", "s", ";"},
      '{"&", "n", "b", "s", "p", ";", CharPad, CharPad},
      '{"&", "m", "i", "n", "u", "s", ";", CharPad}
   };

   localparam logic [0:NumNamed-1][3:0] NamedLen = '{
      4'd5, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd8, 4'd6, 4'd7
   };

   localparam logic [0:NumNamed-1][7:0] NamedValue = '{
      8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h2B, 8'h3D, 8'h20, 8'h2D
   };

   // Entries that are only recognized at the extended level.
   localparam logic [0:NumNamed-1] NamedExtraOnly = 9'b000000011;

   typedef struct packed {
      logic [PendDepth-1:0][7:0] bytes;
      logic [CntW-1:0]           len;
      logic                      is_cp;
      logic [CpW-1:0]            cp;
      logic                      last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/core/hesd_front.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder front end
// Accepts input bytes, tracks the open reference and issues output commands.
// ----------------------------------------------------------------------------
module hesd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [1:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  hesd_pkg::q_status_type q_status,
   output logic                  push,
   output hesd_pkg::cmd_type     push_cmd
);
   import hesd_pkg::*;

   typedef enum logic [2:0] {
      NUM_OFF,
      NUM_AMP,
      NUM_HASH,
      NUM_HEX,
      NUM_DEC
   } num_phase_type;

   logic [1:0]                level_ff;
   logic [CntW-1:0]           pcnt_ff, pcnt_in;
   logic [0:NumNamed-1]       named_ff, named_in;
   num_phase_type             phase_ff, phase_in;
   logic [ValW-1:0]           val_ff, val_in;
   logic [DigW-1:0]           dig_ff, dig_in;
   logic [PendDepth-1:0][7:0] pend_ff, pend_in;

   logic                accept, pend_empty, is_amp;
   logic                numeric_en;
   logic [0:NumNamed-1] named_start, named_hit, named_done;
   logic                named_more, named_fin;
   logic [7:0]          named_val;
   logic                num_more, num_fin;
   num_phase_type       num_phase;
   logic [ValW-1:0]     num_val;
   logic [DigW-1:0]     num_dig;
   logic                fin, more, dead, hold, restart;
   num_phase_type       start_phase;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= "0" && c <= "9") begin
         r = {1'b0, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         r = {1'b0, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b0, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic [4:0] dec_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= "0" && c <= "9") begin
         r = {1'b0, 4'(c - "0")};
      end
      return r;
   endfunction

   assign req_tready  = !q_status.full;
   assign accept      = req_tvalid && req_tready;
   assign pend_empty  = (pcnt_ff == '0);
   assign is_amp      = (req_tdata == CharAmp);
   assign numeric_en  = (level_ff == LevelNumeric) || (level_ff == LevelExtra);
   assign named_start = (level_ff == LevelExtra) ? '1 : ~NamedExtraOnly;
   assign start_phase = numeric_en ? NUM_AMP : NUM_OFF;

   always_comb begin
      named_val = '0;
      for (int i = 0; i < NumNamed; i++) begin
         named_hit[i]  = named_ff[i] && (pcnt_ff < CntW'(NamedLen[i]))
                         && (NamedText[i][pcnt_ff[NamedPosW-1:0]] == req_tdata);
         named_done[i] = named_hit[i] && (pcnt_ff == CntW'(NamedLen[i] - 4'd1));
         if (named_done[i]) begin
            named_val = NamedValue[i];
         end
      end
      named_more = |(named_hit & ~named_done);
      named_fin  = |named_done;
   end

   always_comb begin
      logic [4:0] d;
      d         = (phase_ff == NUM_HEX) ? hex_digit(req_tdata) : dec_digit(req_tdata);
      num_more  = 1'b0;
      num_fin   = 1'b0;
      num_phase = NUM_OFF;
      num_val   = val_ff;
      num_dig   = dig_ff;
      case (phase_ff)
         NUM_AMP: begin
            if (req_tdata == CharHash) begin
               num_more  = 1'b1;
               num_phase = NUM_HASH;
            end
         end
         NUM_HASH: begin
            if (req_tdata == CharX) begin
               num_more  = 1'b1;
               num_phase = NUM_HEX;
               num_val   = '0;
               num_dig   = '0;
            end else if (!d[4]) begin
               num_more  = 1'b1;
               num_phase = NUM_DEC;
               num_val   = ValW'(d[3:0]);
               num_dig   = DigW'(1);
            end
         end
         NUM_HEX, NUM_DEC: begin
            if (req_tdata == CharSemi) begin
               num_fin = (dig_ff != '0) && (32'(val_ff) <= CodeMax);
            end else if (!d[4] && (dig_ff < DigW'(MaxDigits))) begin
               num_more  = 1'b1;
               num_phase = phase_ff;
               num_dig   = dig_ff + 1'b1;
               if (phase_ff == NUM_HEX) begin
                  num_val = (val_ff << 4) | ValW'(d[3:0]);
               end else begin
                  num_val = (val_ff << 3) + (val_ff << 1) + ValW'(d[3:0]);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign fin     = !pend_empty && (named_fin || num_fin);
   assign more    = !pend_empty && !fin && (named_more || num_more);
   assign dead    = !pend_empty && !fin && !more;
   assign hold    = !req_tlast && ((pend_empty && is_amp) || more);
   assign restart = is_amp && !req_tlast && dead;
   assign push    = accept && !hold;

   always_comb begin
      for (int i = 0; i < PendDepth; i++) begin
         pend_in[i] = (pcnt_ff == CntW'(i)) ? req_tdata : pend_ff[i];
      end
      push_cmd.bytes = pend_in;
      if (fin && named_fin) begin
         push_cmd.bytes[0] = named_val;
      end
      if (pend_empty || (fin && named_fin)) begin
         push_cmd.len = CntW'(1);
      end else if (fin) begin
         push_cmd.len = '0;
      end else if (restart) begin
         push_cmd.len = pcnt_ff;
      end else begin
         push_cmd.len = pcnt_ff + 1'b1;
      end
      push_cmd.is_cp = fin && !named_fin;
      push_cmd.cp    = CpW'(val_ff);
      push_cmd.last  = req_tlast;
   end

   always_comb begin
      pcnt_in  = pcnt_ff;
      named_in = named_ff;
      phase_in = phase_ff;
      val_in   = val_ff;
      dig_in   = dig_ff;
      if (accept) begin
         if (hold && pend_empty) begin
            pcnt_in  = CntW'(1);
            named_in = named_start;
            phase_in = start_phase;
         end else if (hold) begin
            pcnt_in  = pcnt_ff + 1'b1;
            named_in = named_hit;
            phase_in = num_phase;
            val_in   = num_val;
            dig_in   = num_dig;
         end else if (restart) begin
            pcnt_in  = CntW'(1);
            named_in = named_start;
            phase_in = start_phase;
         end else begin
            pcnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LevelNamed;
         pcnt_ff  <= '0;
         named_ff <= '0;
         phase_ff <= NUM_OFF;
         val_ff   <= '0;
         dig_ff   <= '0;
      end else begin
         if (csr_wen) begin
            level_ff <= csr_wdata;
         end
         pcnt_ff  <= pcnt_in;
         named_ff <= named_in;
         phase_ff <= phase_in;
         val_ff   <= val_in;
         dig_ff   <= dig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

@@ rtl/core/hesd_queue.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module hesd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hesd_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output hesd_pkg::cmd_type      head_cmd,
   output hesd_pkg::q_status_type status
);
   import hesd_pkg::*;

   cmd_type          slot_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/hesd_back.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder back end
// Expands commands into output bytes, including UTF-8 encoding of code points.
// ----------------------------------------------------------------------------
module hesd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hesd_pkg::cmd_type      head_cmd,
   input  hesd_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import hesd_pkg::*;

   logic [PendDepth-1:0][7:0] vec_ff, vec_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      last_ff, last_in;
   logic [PendDepth-1:0][7:0] utf_vec;
   logic [CntW-1:0]           utf_len;

   always_comb begin
      logic [CpW-1:0] cp;
      cp      = head_cmd.cp;
      utf_vec = '0;
      if (cp < CpW'(32'h80)) begin
         utf_vec[0] = cp[7:0];
         utf_len    = CntW'(1);
      end else if (cp < CpW'(32'h800)) begin
         utf_vec[0] = {3'b110, cp[10:6]};
         utf_vec[1] = {2'b10, cp[5:0]};
         utf_len    = CntW'(2);
      end else if (cp < CpW'(32'h10000)) begin
         utf_vec[0] = {4'b1110, cp[15:12]};
         utf_vec[1] = {2'b10, cp[11:6]};
         utf_vec[2] = {2'b10, cp[5:0]};
         utf_len    = CntW'(3);
      end else begin
         utf_vec[0] = {5'b11110, cp[20:18]};
         utf_vec[1] = {2'b10, cp[17:12]};
         utf_vec[2] = {2'b10, cp[11:6]};
         utf_vec[3] = {2'b10, cp[5:0]};
         utf_len    = CntW'(4);
      end
   end

   always_comb begin
      pop     = 1'b0;
      vec_in  = vec_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if ((cnt_ff > CntW'(1)) && rsp_tready) begin
         vec_in = vec_ff >> 8;
         cnt_in = cnt_ff - 1'b1;
      end else if ((cnt_ff == '0) || rsp_tready) begin
         cnt_in = '0;
         if (!q_status.empty) begin
            pop     = 1'b1;
            last_in = head_cmd.last;
            if (head_cmd.is_cp) begin
               vec_in = utf_vec;
               cnt_in = utf_len;
            end else begin
               vec_in = head_cmd.bytes;
               cnt_in = head_cmd.len;
            end
         end
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = vec_ff[0];
   assign rsp_tlast  = last_ff && (cnt_ff == CntW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      last_ff <= last_in;
   end

endmodule

@@ rtl/core/html_entity_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder
// Replaces HTML character references in a byte stream with decoded bytes.
// ----------------------------------------------------------------------------
// The decoder takes one input byte per cycle until the 4-entry command queue
// between the front end and the back end is full, and delivers one output byte
// per cycle while rsp_tready is high. A byte that closes a reference, fails a
// candidate reference or ends the text turns into a burst of 1 to 10 output
// bytes (UTF-8 of up to 4 bytes, or the held bytes of a failed candidate) for
// the back end to send. The user must write the decode level via csr_wen and
// csr_wdata only while the decoder is idle; the block does not enforce it.
module html_entity_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic [1:0] csr_wdata,    // decode_level
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // out_byte
   output logic       rsp_tlast
);
   import hesd_pkg::*;

   q_status_type q_status;
   logic         push, pop;
   cmd_type      push_cmd, head_cmd;

   hesd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   hesd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   hesd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/hesd_checker.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hesd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Output item changed while stalled.");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Output item present right after reset.");

   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("Input not ready right after reset.");

endmodule

bind html_entity_stream_decoder hesd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/entity_decode_monitor.sv @@
// ----------------------------------------------------------------------------
// Entity decode monitor
// Watches both streams of the HTML entity stream decoder, decodes every
// accepted input byte with its own model of the reference matcher and
// compares each delivered byte and last flag with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_decode_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic [1:0] csr_wdata,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         expected_left
);
   import hesd_pkg::*;

   localparam int MaxBurst = 12;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_byte_type;

   typedef enum logic [1:0] {
      RefDead,
      RefOpen,
      RefDone
   } ref_state_type;

   logic [1:0]       level;
   logic [7:0]       held [0:15];
   int               held_len;
   int               errors = 0;
   decoded_byte_type decoded_q [$];
   decoded_byte_type burst_q [$];

   task automatic report_mismatch(input string what);
      if (errors < 100) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      errors++;
   endtask

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c - "0");
      end
      if (c >= "a" && c <= "f") begin
         return int'(c - "a") + 10;
      end
      if (c >= "A" && c <= "F") begin
         return int'(c - "A") + 10;
      end
      return -1;
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      decoded_byte_type item;
      item.data = b;
      item.last = 1'b0;
      burst_q.push_back(item);
   endfunction

   function automatic void emit_code_point(logic [31:0] v);
      if (v < 32'h80) begin
         emit_byte(v[7:0]);
      end else if (v < 32'h800) begin
         emit_byte({3'b110, v[10:6]});
         emit_byte({2'b10, v[5:0]});
      end else if (v < 32'h10000) begin
         emit_byte({4'b1110, v[15:12]});
         emit_byte({2'b10, v[11:6]});
         emit_byte({2'b10, v[5:0]});
      end else begin
         emit_byte({5'b11110, v[20:18]});
         emit_byte({2'b10, v[17:12]});
         emit_byte({2'b10, v[11:6]});
         emit_byte({2'b10, v[5:0]});
      end
   endfunction

   // Judges the held candidate against the references the current level allows.
   function automatic ref_state_type classify_held(output logic [31:0] value,
                                                   output logic numeric);
      int         i;
      int         j;
      int         k;
      int         n;
      int         start;
      int         d;
      logic       same;
      logic       is_hex;
      logic       numeric_ok;
      logic       extra_ok;
      logic [7:0] c;
      logic [31:0] v;
      n = held_len;
      value = '0;
      numeric = 1'b0;
      numeric_ok = (level == LevelNumeric) || (level == LevelExtra);
      extra_ok = (level == LevelExtra);
      for (i = 0; i < NumNamed; i++) begin
         if (NamedExtraOnly[i] && !extra_ok) begin
            continue;
         end
         if (n <= int'(NamedLen[i])) begin
            same = 1'b1;
            for (j = 0; j < n; j++) begin
               if (held[j] != NamedText[i][j]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               if (n == int'(NamedLen[i])) begin
                  value = {24'd0, NamedValue[i]};
                  return RefDone;
               end
               return RefOpen;
            end
         end
      end
      if (!numeric_ok) begin
         return RefDead;
      end
      if (n <= 1) begin
         return RefOpen;
      end
      if (held[1] != CharHash) begin
         return RefDead;
      end
      if (n == 2) begin
         return RefOpen;
      end
      is_hex = (held[2] == CharX);
      start = is_hex ? 3 : 2;
      v = '0;
      for (k = start; k < n; k++) begin
         c = held[k];
         if (is_hex) begin
            d = hex_digit(c);
         end else begin
            d = (c >= "0" && c <= "9") ? int'(c - "0") : -1;
         end
         if (c == CharSemi) begin
            if (k == start || k != n - 1) begin
               return RefDead;
            end
            if (v > CodeMax) begin
               return RefDead;
            end
            value = v;
            numeric = 1'b1;
            return RefDone;
         end
         if (d < 0 || (k - start) >= MaxDigits) begin
            return RefDead;
         end
         v = is_hex ? ((v << 4) | d) : (v * 10 + d);
      end
      return RefOpen;
   endfunction

   // Decodes one input item and queues the bytes it releases. A failed
   // candidate gives up its ampersand and its other bytes are matched again.
   function automatic void decode_item(logic [7:0] b, logic last);
      logic [7:0]    work [$];
      logic [7:0]    cur;
      logic [31:0]   v;
      logic          numeric;
      ref_state_type st;
      int            k;
      burst_q.delete();
      work.push_back(b);
      while (work.size() > 0) begin
         cur = work.pop_front();
         if (held_len == 0) begin
            if (cur == CharAmp) begin
               held[0] = cur;
               held_len = 1;
            end else begin
               emit_byte(cur);
            end
            continue;
         end
         held[held_len] = cur;
         held_len++;
         st = classify_held(v, numeric);
         if (st == RefOpen) begin
            continue;
         end
         if (st == RefDone) begin
            held_len = 0;
            if (numeric) begin
               emit_code_point(v);
            end else begin
               emit_byte(v[7:0]);
            end
            continue;
         end
         emit_byte(held[0]);
         for (k = held_len - 1; k >= 1; k--) begin
            work.push_front(held[k]);
         end
         held_len = 0;
      end
      if (last) begin
         for (k = 0; k < held_len; k++) begin
            emit_byte(held[k]);
         end
         held_len = 0;
      end
      while (burst_q.size() > MaxBurst) begin
         void'(burst_q.pop_back());
      end
      if (last && burst_q.size() > 0) begin
         burst_q[burst_q.size() - 1].last = 1'b1;
      end
      foreach (burst_q[m]) begin
         decoded_q.push_back(burst_q[m]);
      end
   endfunction

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         level = LevelNamed;
         held_len = 0;
         decoded_q.delete();
      end else begin
         if (csr_wen) begin
            level = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            decode_item(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected item %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  report_mismatch($sformatf("byte %h, expected %h", rsp_tdata, want.data));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last %b on byte %h, expected %b",
                                            rsp_tlast, rsp_tdata, want.last));
               end
            end
         end
      end
      fail_count <= errors;
      expected_left <= decoded_q.size();
   end

endmodule

@@ tb/html_entity_stream_decoder_test.sv @@
// ----------------------------------------------------------------------------
// HTML entity stream decoder test
// Feeds texts of directed and random references through the decoder at every
// decode level, with bursty input, a stalling output and one long output
// hold-off, and lets the monitor check every decoded byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_entity_stream_decoder_test;
   import hesd_pkg::*;

   localparam logic [1:0] LevelAlias    = 2'd3;
   localparam int         NumPhases     = 12;
   localparam int         PressurePhase = 4;
   localparam int         HoldOffCycles = 150;
   localparam int         SettleCycles  = 16;
   localparam int         WatchdogLimit = 2000;

   localparam logic [0:NumPhases-1][1:0] PhaseLevel = {
      LevelNamed, LevelAlias, LevelNumeric, LevelExtra, LevelNumeric, LevelExtra,
      LevelNamed, LevelNumeric, LevelExtra, LevelAlias, LevelNumeric, LevelExtra
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wen = 1'b0;
   logic [1:0] csr_wdata = '0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int         fail_count;
   int         expected_left;
   int         idle_cycles = 0;
   int         burst_left = 0;
   int         ready_count = 0;
   int         ready_mode = 0;
   logic       hold_off_go = 1'b0;
   logic       hold_off_done = 1'b0;
   logic [7:0] line_bytes [$];

   html_entity_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   entity_decode_monitor monitor (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // The output side switches among random stall patterns and holds off once for
   // a long stretch while the input side keeps offering items.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end
         ready_count++;
         if (ready_count % 40 == 0) begin
            ready_mode = $urandom_range(0, 3);
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= (ready_count % 4) != 3;
            2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         line_bytes.push_back(s[i]);
      end
   endfunction

   function automatic logic [31:0] pick_code_point();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 'h7F);
         1: return $urandom_range('h80, 'h7FF);
         2: return $urandom_range('h800, 'hFFFF);
         3: return $urandom_range('h10000, 'h10FFFF);
         4: return ($urandom_range(0, 1) == 0) ? 32'h10FFFF : 32'h110000;
         default: return $urandom_range('h110000, 'hFFFFFF);
      endcase
   endfunction

   // Appends one piece of text: a named or numeric reference with random
   // content, plain bytes, or a broken or cut-off reference.
   task automatic add_random_segment();
      int          idx;
      int          n;
      int          i;
      int          nmin;
      logic [31:0] v;
      logic [3:0]  nib;
      string       s;
      case ($urandom_range(0, 9))
         0, 1: line_bytes.push_back(8'($urandom_range(0, 255)));
         2, 3: begin
            idx = $urandom_range(0, NumNamed - 1);
            for (i = 0; i < int'(NamedLen[idx]); i++) begin
               line_bytes.push_back(NamedText[idx][i]);
            end
         end
         4: begin
            idx = $urandom_range(0, NumNamed - 1);
            n = $urandom_range(1, int'(NamedLen[idx]) - 1);
            for (i = 0; i < n; i++) begin
               line_bytes.push_back(NamedText[idx][i]);
            end
         end
         5, 6: begin
            v = pick_code_point();
            nmin = 1;
            while ((v >> (4 * nmin)) != 0) begin
               nmin++;
            end
            n = ($urandom_range(0, 7) == 0) ? 7 : $urandom_range(nmin, 6);
            add_text("&#x");
            for (i = n - 1; i >= 0; i--) begin
               nib = (i < 8) ? v[4*i +: 4] : 4'd0;
               if (nib < 10) begin
                  line_bytes.push_back("0" + nib);
               end else if ($urandom_range(0, 1) == 0) begin
                  line_bytes.push_back("a" + nib - 10);
               end else begin
                  line_bytes.push_back("A" + nib - 10);
               end
            end
            if ($urandom_range(0, 7) != 0) begin
               add_text(";");
            end
         end
         7: begin
            v = pick_code_point();
            s = $sformatf("%0d", v);
            add_text("&#");
            if (s.len() < 6 && $urandom_range(0, 3) == 0) begin
               for (i = s.len(); i < 6; i++) begin
                  add_text("0");
               end
            end
            add_text(s);
            add_text(";");
         end
         8: begin
            case ($urandom_range(0, 2))
               0: add_text("&#;");
               1: begin
                  add_text("&#X");
                  line_bytes.push_back("0" + 8'($urandom_range(0, 9)));
                  add_text(";");
               end
               default: begin
                  add_text("&");
                  line_bytes.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
         default: begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++) begin
               line_bytes.push_back(8'($urandom_range(32, 126)));
            end
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < line_bytes.size(); i++) begin
         push_byte(line_bytes[i], i == line_bytes.size() - 1);
      end
      req_tvalid <= 1'b0;
      line_bytes.delete();
   endtask

   task automatic drain_decoder();
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_level(input logic [1:0] lvl);
      csr_wen <= 1'b1;
      csr_wdata <= lvl;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int phase;
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Zero and all-ones bytes, the largest code point, an uppercase X after
      // the hash, and a candidate cut off by the end of the text.
      write_level(LevelExtra);
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      add_text("&#x10FFFF;&#X1;&minus");
      send_text();
      drain_decoder();

      // A value just past the code point range, then code point zero.
      write_level(LevelNumeric);
      add_text("&#x110000;&#0;");
      send_text();
      drain_decoder();

      for (phase = 0; phase < NumPhases; phase++) begin
         write_level(PhaseLevel[phase]);
         if (phase == PressurePhase) begin
            hold_off_go <= 1'b1;
            target = 90;
         end else begin
            target = $urandom_range(15, 35);
         end
         while (line_bytes.size() < target) begin
            add_random_segment();
         end
         send_text();
         drain_decoder();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
